[rtl/core/mfpd_pkg.sv]
// Shared widths and framing constants of the marker-framed packet deframer.
package mfpd_pkg;

   localparam int unsigned ByteW     = 8;
   localparam int unsigned WordW     = 32;
   localparam int unsigned LenW      = 13;
   localparam int unsigned RunW      = 3;
   localparam int unsigned PosW      = 4;

   localparam logic [ByteW-1:0] MarkerByte  = 8'hFF;
   localparam logic [RunW-1:0]  MarkerLen   = 3'd4;
   localparam logic [PosW-1:0]  HeaderLast  = 4'd11;   // index of the twelfth header byte
   localparam logic [LenW-1:0]  MaxLenReset = 13'd4096;

   // One result beat as held in the output register.
   typedef struct packed {
      logic [ByteW-1:0] payload_byte;
      logic             byte_valid;
      logic             packet_last;
      logic [WordW-1:0] packet_sample_id;
      logic [WordW-1:0] packet_time;
      logic             length_error;
      logic [WordW-1:0] broken_total;
   } rsp_type;

endpackage

[rtl/core/marker_framed_packet_deframer_unit.sv]
// Top level of the marker-framed packet deframer: marker hunt, header capture, payload pass.
//
//   channel | direction | ports                          | beat
//   --------+-----------+--------------------------------+--------------------------------
//   req     | in        | req_valid, req_stall, req_*    | one received byte
//   rsp     | out       | rsp_valid, rsp_stall, rsp_*    | one payload byte or packet end
//   csr     | in        | csr_wr_en, csr_wr_data         | max_payload_len write
//
// One byte is taken per cycle while req_stall is low; its state update and any result are
// worked out in the same cycle and the result lands in the output register on the accepting
// edge. A byte gives zero or one result; the result appears in the cycle after its byte.
// req_stall rises only while the output register holds a beat that rsp_stall holds back,
// so a new byte is taken in the cycle the waiting beat leaves.
// Synchronous reset returns to the marker hunt, clears the counters and sets the length
// limit to 4096.
module marker_framed_packet_deframer_unit
   import mfpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // received byte stream
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ByteW-1:0] req_rx_byte,
   // packet payload stream
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ByteW-1:0] rsp_payload_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_packet_last,
   output logic [WordW-1:0] rsp_packet_sample_id,
   output logic [WordW-1:0] rsp_packet_time,
   output logic             rsp_length_error,
   output logic [WordW-1:0] rsp_broken_total,
   // configuration
   input  logic             csr_wr_en,
   input  logic [LenW-1:0]  csr_wr_data
);

   // phase codes; the spare code behaves as hunting
   localparam logic [1:0] PhHunt    = 2'd0;
   localparam logic [1:0] PhHeader  = 2'd1;
   localparam logic [1:0] PhPayload = 2'd2;

   logic [1:0]       phase_ff,        phase_in;
   logic [RunW-1:0]  marker_run_ff,   marker_run_in;
   logic [PosW-1:0]  header_pos_ff,   header_pos_in;
   logic [WordW-1:0] id_ff,           id_in;
   logic [WordW-1:0] time_ff,         time_in;
   logic [WordW-1:0] length_ff,       length_in;
   logic [LenW-1:0]  bytes_left_ff,   bytes_left_in;
   logic             broken_flag_ff,  broken_flag_in;
   logic [WordW-1:0] broken_count_ff, broken_count_in;
   logic [LenW-1:0]  max_len_ff,      max_len_in;

   logic             rsp_valid_ff,    rsp_valid_in;
   rsp_type          rsp_ff,          rsp_in;
   logic             emit;

   logic             accept;
   logic [4:0]       lane;
   logic [RunW-1:0]  run_next;

   // hold input while a finished beat is waiting on a stalled consumer
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign lane      = {header_pos_ff[1:0], 3'b000};
   assign run_next  = marker_run_ff + RunW'(1);

   assign max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;

   always_comb begin
      phase_in        = phase_ff;
      marker_run_in   = marker_run_ff;
      header_pos_in   = header_pos_ff;
      id_in           = id_ff;
      time_in         = time_ff;
      length_in       = length_ff;
      bytes_left_in   = bytes_left_ff;
      broken_flag_in  = broken_flag_ff;
      broken_count_in = broken_count_ff;
      emit            = 1'b0;
      rsp_in          = rsp_ff;

      if (accept) begin
         case (phase_ff)
            PhHeader: begin
               // drop the byte into its lane of the word it belongs to
               if (header_pos_ff[3:2] == 2'd0) begin
                  id_in[lane +: ByteW] = req_rx_byte;
               end else if (header_pos_ff[3:2] == 2'd1) begin
                  time_in[lane +: ByteW] = req_rx_byte;
               end else begin
                  length_in[lane +: ByteW] = req_rx_byte;
               end
               header_pos_in = header_pos_ff + PosW'(1);
               if (header_pos_ff == HeaderLast) begin
                  rsp_in.payload_byte     = '0;
                  rsp_in.byte_valid       = 1'b0;
                  rsp_in.packet_last      = 1'b1;
                  rsp_in.packet_sample_id = id_in;
                  rsp_in.packet_time      = time_in;
                  rsp_in.broken_total     = broken_count_ff;
                  rsp_in.length_error     = 1'b0;
                  if (length_in > WordW'(max_len_ff)) begin
                     // announced length too long: flag it and hunt again
                     emit                = 1'b1;
                     rsp_in.length_error = 1'b1;
                     phase_in            = PhHunt;
                     marker_run_in       = '0;
                     header_pos_in       = '0;
                     bytes_left_in       = '0;
                  end else if (length_in == '0) begin
                     // empty packet: one end beat with no data
                     emit          = 1'b1;
                     phase_in      = PhHunt;
                     marker_run_in = '0;
                     header_pos_in = '0;
                     bytes_left_in = '0;
                  end else begin
                     bytes_left_in = length_in[LenW-1:0];
                     header_pos_in = '0;
                     phase_in      = PhPayload;
                  end
               end
            end
            PhPayload: begin
               emit                    = 1'b1;
               rsp_in.payload_byte     = req_rx_byte;
               rsp_in.byte_valid       = 1'b1;
               rsp_in.packet_sample_id = id_ff;
               rsp_in.packet_time      = time_ff;
               rsp_in.length_error     = 1'b0;
               rsp_in.broken_total     = broken_count_ff;
               if (bytes_left_ff <= LenW'(1)) begin
                  rsp_in.packet_last = 1'b1;
                  phase_in           = PhHunt;
                  marker_run_in      = '0;
                  header_pos_in      = '0;
                  bytes_left_in      = '0;
               end else begin
                  rsp_in.packet_last = 1'b0;
                  bytes_left_in      = bytes_left_ff - LenW'(1);
               end
            end
            default: begin
               // hunt for the run of marker bytes; anything else marks the stream broken
               phase_in = PhHunt;
               if (req_rx_byte != MarkerByte) begin
                  marker_run_in  = '0;
                  broken_flag_in = 1'b1;
               end else if (run_next >= MarkerLen) begin
                  if (broken_flag_ff) begin
                     broken_count_in = broken_count_ff + WordW'(1);
                  end
                  broken_flag_in = 1'b0;
                  marker_run_in  = '0;
                  header_pos_in  = '0;
                  phase_in       = PhHeader;
               end else begin
                  marker_run_in = run_next;
               end
            end
         endcase
      end
   end

   // output register: load on a new result, clear once the waiting beat is taken
   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PhHunt;
         marker_run_ff   <= '0;
         header_pos_ff   <= '0;
         id_ff           <= '0;
         time_ff         <= '0;
         length_ff       <= '0;
         bytes_left_ff   <= '0;
         broken_flag_ff  <= 1'b0;
         broken_count_ff <= '0;
         max_len_ff      <= MaxLenReset;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         marker_run_ff   <= marker_run_in;
         header_pos_ff   <= header_pos_in;
         id_ff           <= id_in;
         time_ff         <= time_in;
         length_ff       <= length_in;
         bytes_left_ff   <= bytes_left_in;
         broken_flag_ff  <= broken_flag_in;
         broken_count_ff <= broken_count_in;
         max_len_ff      <= max_len_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_payload_byte     = rsp_ff.payload_byte;
   assign rsp_byte_valid       = rsp_ff.byte_valid;
   assign rsp_packet_last      = rsp_ff.packet_last;
   assign rsp_packet_sample_id = rsp_ff.packet_sample_id;
   assign rsp_packet_time      = rsp_ff.packet_time;
   assign rsp_length_error     = rsp_ff.length_error;
   assign rsp_broken_total     = rsp_ff.broken_total;

endmodule

[rtl/core/mfpd_checker.sv]
// Port-level assertions for the marker-framed packet deframer, bound to its top level.
module mfpd_checker
   import mfpd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [ByteW-1:0] rsp_payload_byte,
   input logic             rsp_byte_valid,
   input logic             rsp_packet_last,
   input logic [WordW-1:0] rsp_packet_sample_id,
   input logic [WordW-1:0] rsp_packet_time,
   input logic             rsp_length_error,
   input logic [WordW-1:0] rsp_broken_total
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_byte_valid) && $stable(rsp_packet_last)
         && $stable(rsp_packet_sample_id) && $stable(rsp_packet_time)
         && $stable(rsp_length_error) && $stable(rsp_broken_total))
      else $error("stalled result beat changed");

   // input is held back only by a waiting result beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output register");

   // a data beat never carries a length error
   a_data_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_length_error)
      else $error("data beat flagged as length error");

   // a beat without data ends its packet and carries a zero byte
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_packet_last && (rsp_payload_byte == '0))
      else $error("dataless beat not a packet end");

   // a length error is always a dataless end beat
   a_err_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |-> rsp_packet_last && !rsp_byte_valid)
      else $error("length error beat malformed");

endmodule

bind marker_framed_packet_deframer_unit mfpd_checker u_mfpd_checker (.*);
